// File: rtl/sorted_slot_table_assert.svh
// assertion macros shared by the sorted slot table rtl
// expects clk and arst_n in the scope of each use; no other dependencies
`ifndef SORTED_SLOT_TABLE_ASSERT_SVH
`define SORTED_SLOT_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SST_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition must never be seen outside reset
`define SST_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define SST_ASSERT(name, prop, msg)
`define SST_NEVER(name, cond, msg)
`endif
`endif

// File: rtl/sst_pkg.sv
// shared types and constants for the sorted slot table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

	// request codes
	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_LIST   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	// result status codes
	typedef enum logic [3:0] {
		ST_ADDED     = 4'd0,
		ST_BAD_DATE  = 4'd1,
		ST_DUPLICATE = 4'd2,
		ST_DELETED   = 4'd3,
		ST_NOT_FOUND = 4'd4,
		ST_EMPTY     = 4'd5,
		ST_FULL      = 4'd6,
		ST_LIST      = 4'd7,
		ST_CLEARED   = 4'd8
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_PUT,
		S_LIST
	} state_t;

	// key, month in the top bits so a plain compare gives date order
	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
	} key_t;

	// one result from the sequencer to the output register
	typedef struct packed {
		logic    valid;
		status_t status;
		key_t    key;
		logic    last;
	} res_t;

	localparam logic [3:0] MONTH_MAX = 4'd12;
	localparam logic [4:0] DAY_MAX   = 5'd31;
	localparam logic [4:0] HOUR_MAX  = 5'd24;

endpackage

`default_nettype wire

// File: rtl/sorted_slot_table.sv
// sorted_slot_table top level: key memory, sequencer and result register
// depends on sst_pkg, sst_mem and sst_seq
//
//   channel   signals                              handshake
//   request   start, req_type, month, day, hour    taken when start && !busy
//   result    done, status, out_month, out_day,    valid for the one cycle done
//             out_hour, last                       is high, no back pressure
//
// clear, bad date and any request on an empty table: finished straight from idle
// insert: search, then rejected or appended, or keys move up and the new key is put
// delete: search, then keys above the match move down; list: every stored key in order
// results appear in the cycle after the sequencer produces them
// arst_n empties the table; stored keys keep no reset value and are never read stale
`timescale 1ns / 1ps
`default_nettype none

module sorted_slot_table #(
	parameter int SLOTS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] req_type,
	input  wire logic [3:0] month,
	input  wire logic [4:0] day,
	input  wire logic [4:0] hour,
	output logic            done,
	output logic [3:0]      status,
	output logic [3:0]      out_month,
	output logic [4:0]      out_day,
	output logic [4:0]      out_hour,
	output logic            last
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	sst_pkg::key_t   key_in;
	sst_pkg::key_t   mem_wdata;
	sst_pkg::key_t   mem_rdata;
	sst_pkg::res_t   res;
	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [AW-1:0]   mem_raddr;

	logic            done_q;
	sst_pkg::res_t   res_q;

	assign key_in.month = month;
	assign key_in.day   = day;
	assign key_in.hour  = hour;

	sst_mem #(
		.SLOTS (SLOTS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sst_seq #(
		.SLOTS (SLOTS),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (sst_pkg::req_t'(req_type)),
		.key_in    (key_in),
		.busy      (busy),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.res       (res)
	);

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			res_q <= res;
		end
	end

	assign done      = done_q;
	assign status    = res_q.status;
	assign out_month = res_q.key.month;
	assign out_day   = res_q.key.day;
	assign out_hour  = res_q.key.hour;
	assign last      = res_q.last;

endmodule

`default_nettype wire

// File: rtl/sst_mem.sv
// key storage: one write port, one read port with registered read data
// depends on sst_pkg for the key type
`timescale 1ns / 1ps
`default_nettype none

module sst_mem #(
	parameter int SLOTS = 32,
	parameter int AW    = 5
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire sst_pkg::key_t wdata,
	input  wire logic [AW-1:0] raddr,
	output sst_pkg::key_t      rdata
);

	sst_pkg::key_t mem_q [SLOTS];
	sst_pkg::key_t rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/sst_seq.sv
// sequencer: walks the key memory through one shared key comparator
// depends on sst_pkg and sorted_slot_table_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_slot_table_assert.svh"

module sst_seq #(
	parameter int SLOTS = 32,
	parameter int AW    = 5,
	parameter int CW    = 6
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire sst_pkg::req_t req,
	input  wire sst_pkg::key_t key_in,
	output logic               busy,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output sst_pkg::key_t      mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  wire sst_pkg::key_t mem_rdata,
	output sst_pkg::res_t      res
);

	sst_pkg::state_t state_q, state_d;
	sst_pkg::req_t   req_q, req_d;
	sst_pkg::key_t   key_q, key_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   pos_q, pos_d;

	logic [CW-1:0]   count_m1;
	logic [AW-1:0]   last_idx;
	logic [AW-1:0]   idx_inc;
	logic [AW-1:0]   idx_dec;
	logic            full;
	logic            at_last;
	logic            key_lt;
	logic            key_eq;
	logic            key_ok;

	// shared comparator and index helpers
	assign count_m1 = count_q - CW'(1);
	assign last_idx = count_m1[AW-1:0];
	assign idx_inc  = idx_q + AW'(1);
	assign idx_dec  = idx_q - AW'(1);
	assign full     = (count_q == CW'(SLOTS));
	assign at_last  = (idx_q == last_idx);
	assign key_lt   = (mem_rdata < key_q);
	assign key_eq   = (mem_rdata == key_q);

	// date range check on the incoming key
	always_comb begin
		key_ok = (key_in.month inside {[4'd1:sst_pkg::MONTH_MAX]})
			&& (key_in.day inside {[5'd1:sst_pkg::DAY_MAX]})
			&& (key_in.hour inside {[5'd1:sst_pkg::HOUR_MAX]});
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sst_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	// working registers of the current request
	always_ff @(posedge clk) begin
		req_q <= req_d;
		key_q <= key_d;
		idx_q <= idx_d;
		pos_q <= pos_d;
	end

	// next state, memory control and results
	always_comb begin
		state_d    = state_q;
		req_d      = req_q;
		key_d      = key_q;
		count_d    = count_q;
		idx_d      = idx_q;
		pos_d      = pos_q;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = key_q;
		mem_raddr  = idx_inc;
		res.valid  = 1'b0;
		res.status = sst_pkg::ST_ADDED;
		res.key    = key_q;
		res.last   = 1'b1;
		case (state_q)
			sst_pkg::S_IDLE: begin
				mem_raddr = '0;
				if (start) begin
					req_d = req;
					key_d = key_in;
					idx_d = '0;
					res.key = key_in;
					case (req)
						sst_pkg::REQ_INSERT: begin
							if (!key_ok) begin
								res.valid  = 1'b1;
								res.status = sst_pkg::ST_BAD_DATE;
							end else if (count_q == '0) begin
								mem_we     = 1'b1;
								mem_wdata  = key_in;
								count_d    = CW'(1);
								res.valid  = 1'b1;
								res.status = sst_pkg::ST_ADDED;
							end else begin
								state_d = sst_pkg::S_SEARCH;
							end
						end
						sst_pkg::REQ_DELETE: begin
							if (count_q == '0) begin
								res.valid  = 1'b1;
								res.status = sst_pkg::ST_EMPTY;
							end else begin
								state_d = sst_pkg::S_SEARCH;
							end
						end
						sst_pkg::REQ_LIST: begin
							if (count_q == '0) begin
								res.valid  = 1'b1;
								res.status = sst_pkg::ST_EMPTY;
								res.key    = '0;
							end else begin
								state_d = sst_pkg::S_LIST;
							end
						end
						sst_pkg::REQ_CLEAR: begin
							count_d    = '0;
							res.valid  = 1'b1;
							res.status = sst_pkg::ST_CLEARED;
							res.key    = '0;
						end
						default: begin
						end
					endcase
				end
			end
			// one stored key compared per cycle, next key prefetched
			sst_pkg::S_SEARCH: begin
				idx_d = idx_inc;
				if (req_q == sst_pkg::REQ_INSERT) begin
					if (key_eq) begin
						res.valid  = 1'b1;
						res.status = sst_pkg::ST_DUPLICATE;
						state_d    = sst_pkg::S_IDLE;
					end else if (!key_lt || at_last) begin
						if (full) begin
							res.valid  = 1'b1;
							res.status = sst_pkg::ST_FULL;
							state_d    = sst_pkg::S_IDLE;
						end else if (key_lt) begin
							// new key goes after every stored key
							mem_we     = 1'b1;
							mem_waddr  = count_q[AW-1:0];
							count_d    = count_q + CW'(1);
							res.valid  = 1'b1;
							res.status = sst_pkg::ST_ADDED;
							state_d    = sst_pkg::S_IDLE;
						end else begin
							pos_d     = CW'(idx_q);
							mem_raddr = last_idx;
							idx_d     = last_idx;
							state_d   = sst_pkg::S_SHIFT_UP;
						end
					end
				end else begin
					if (key_eq) begin
						if (at_last) begin
							count_d    = count_m1;
							res.valid  = 1'b1;
							res.status = sst_pkg::ST_DELETED;
							state_d    = sst_pkg::S_IDLE;
						end else begin
							state_d = sst_pkg::S_SHIFT_DN;
						end
					end else if (!key_lt || at_last) begin
						res.valid  = 1'b1;
						res.status = sst_pkg::ST_NOT_FOUND;
						state_d    = sst_pkg::S_IDLE;
					end
				end
			end
			// move keys up one slot, top first
			sst_pkg::S_SHIFT_UP: begin
				mem_we    = 1'b1;
				mem_waddr = idx_inc;
				mem_wdata = mem_rdata;
				if (idx_q == pos_q[AW-1:0]) begin
					state_d = sst_pkg::S_PUT;
				end else begin
					mem_raddr = idx_dec;
					idx_d     = idx_dec;
				end
			end
			// move keys down one slot over the deleted one
			sst_pkg::S_SHIFT_DN: begin
				mem_we    = 1'b1;
				mem_waddr = idx_dec;
				mem_wdata = mem_rdata;
				idx_d     = idx_inc;
				if (at_last) begin
					count_d    = count_m1;
					res.valid  = 1'b1;
					res.status = sst_pkg::ST_DELETED;
					state_d    = sst_pkg::S_IDLE;
				end
			end
			// write the new key into the opened slot
			sst_pkg::S_PUT: begin
				mem_we     = 1'b1;
				mem_waddr  = pos_q[AW-1:0];
				count_d    = count_q + CW'(1);
				res.valid  = 1'b1;
				res.status = sst_pkg::ST_ADDED;
				state_d    = sst_pkg::S_IDLE;
			end
			// one stored key out per cycle
			sst_pkg::S_LIST: begin
				idx_d      = idx_inc;
				res.valid  = 1'b1;
				res.status = sst_pkg::ST_LIST;
				res.key    = mem_rdata;
				res.last   = at_last;
				if (at_last) begin
					state_d = sst_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = sst_pkg::S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != sst_pkg::S_IDLE);

	// checks
	`SST_NEVER(a_count_range, count_q > CW'(SLOTS), "entry count above capacity")
	`SST_ASSERT(a_last_ends, res.valid && res.last |=> state_q == sst_pkg::S_IDLE, "busy after last result")
	`SST_ASSERT(a_clear_empties, start && !busy && req == sst_pkg::REQ_CLEAR |=> count_q == '0, "clear left entries")
	`SST_NEVER(a_list_no_write, mem_we && state_q == sst_pkg::S_LIST, "memory written during list")

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// self-checking testbench for sorted_slot_table: directed and random requests
// against a queue-based model of the sorted key table
// depends on sst_pkg and the sorted_slot_table rtl
`timescale 1ns / 1ps

module testbench;

	localparam int SLOTS = 32;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 16;

	// one result as seen on the result ports
	typedef struct packed {
		sst_pkg::status_t status;
		sst_pkg::key_t    key;
		logic             last;
	} slot_result_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	sst_pkg::req_t req_type = sst_pkg::REQ_INSERT;
	logic [3:0]    month = '0;
	logic [4:0]    day = '0;
	logic [4:0]    hour = '0;
	logic          busy;
	logic          done;
	logic [3:0]    status;
	logic [3:0]    out_month;
	logic [4:0]    out_day;
	logic [4:0]    out_hour;
	logic          last;

	// model of the table: packed keys in ascending order
	logic [13:0]  booked[$];
	slot_result_t awaited[$];

	int  mismatches = 0;
	int  requests_sent = 0;
	int  results_checked = 0;
	int  full_seen = 0;
	int  longest_list = 0;
	bit  steady = 1'b0;

	sorted_slot_table #(.SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req_type (req_type),
		.month    (month),
		.day      (day),
		.hour     (hour),
		.done     (done),
		.status   (status),
		.out_month(out_month),
		.out_day  (out_day),
		.out_hour (out_hour),
		.last     (last)
	);

	always #5 clk = ~clk;

	// queue one predicted result
	function automatic void push_result(sst_pkg::status_t st, logic [13:0] k, logic lst);
		slot_result_t r;
		r.status = st;
		r.key = k;
		r.last = lst;
		awaited.push_back(r);
	endfunction

	// apply one request to the model table and predict its results
	function automatic void book_request(sst_pkg::req_t op, logic [13:0] k);
		sst_pkg::key_t kf;
		int            pos;
		kf = k;
		pos = 0;
		case (op)
			sst_pkg::REQ_INSERT: begin
				while (pos < booked.size() && booked[pos] < k)
					pos++;
				if (kf.month < 1 || kf.month > sst_pkg::MONTH_MAX ||
						kf.day < 1 || kf.day > sst_pkg::DAY_MAX ||
						kf.hour < 1 || kf.hour > sst_pkg::HOUR_MAX) begin
					push_result(sst_pkg::ST_BAD_DATE, k, 1'b1);
				end else if (pos < booked.size() && booked[pos] == k) begin
					push_result(sst_pkg::ST_DUPLICATE, k, 1'b1);
				end else if (booked.size() >= SLOTS) begin
					push_result(sst_pkg::ST_FULL, k, 1'b1);
					full_seen++;
				end else begin
					booked.insert(pos, k);
					push_result(sst_pkg::ST_ADDED, k, 1'b1);
				end
			end
			sst_pkg::REQ_DELETE: begin
				// exact match only, no range check on the key
				while (pos < booked.size() && booked[pos] != k)
					pos++;
				if (booked.size() == 0) begin
					push_result(sst_pkg::ST_EMPTY, k, 1'b1);
				end else if (pos >= booked.size()) begin
					push_result(sst_pkg::ST_NOT_FOUND, k, 1'b1);
				end else begin
					booked.delete(pos);
					push_result(sst_pkg::ST_DELETED, k, 1'b1);
				end
			end
			sst_pkg::REQ_LIST: begin
				if (booked.size() == 0)
					push_result(sst_pkg::ST_EMPTY, '0, 1'b1);
				for (int i = 0; i < booked.size(); i++)
					push_result(sst_pkg::ST_LIST, booked[i], i == booked.size() - 1);
				if (booked.size() > longest_list)
					longest_list = booked.size();
			end
			default: begin
				booked.delete();
				push_result(sst_pkg::ST_CLEARED, '0, 1'b1);
			end
		endcase
	endfunction

	// send one request, with an optional idle burst first
	task automatic send_request(sst_pkg::req_t op, logic [3:0] m, logic [4:0] d,
			logic [4:0] h);
		int gap;
		gap = 0;
		if (!steady && $urandom_range(0, 2) == 0)
			gap = $urandom_range(1, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= op;
		month <= m;
		day <= d;
		hour <= h;
		do
			@(posedge clk);
		while (busy);
		book_request(op, {m, d, h});
		requests_sent++;
	endtask

	// stop sending and wait for every predicted result
	task automatic wait_for_results();
		start <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
	endtask

	function automatic bit is_booked(logic [13:0] k);
		foreach (booked[i])
			if (booked[i] == k)
				return 1'b1;
		return 1'b0;
	endfunction

	// random valid key not yet in the table
	function automatic logic [13:0] fresh_key();
		logic [13:0] k;
		do
			k = {4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)),
				5'($urandom_range(1, 24))};
		while (is_booked(k));
		return k;
	endfunction

	// list, delete and clear on an empty table
	task automatic test_empty_table();
		send_request(sst_pkg::REQ_LIST, 4'd0, 5'd0, 5'd0);
		send_request(sst_pkg::REQ_DELETE, 4'd0, 5'd0, 5'd0);
		send_request(sst_pkg::REQ_DELETE, 4'd15, 5'd31, 5'd31);
		send_request(sst_pkg::REQ_CLEAR, 4'd15, 5'd31, 5'd31);
		wait_for_results();
	endtask

	// out of range keys on insert
	task automatic test_key_checks();
		send_request(sst_pkg::REQ_INSERT, 4'd0, 5'd1, 5'd1);
		send_request(sst_pkg::REQ_INSERT, 4'd13, 5'd1, 5'd1);
		send_request(sst_pkg::REQ_INSERT, 4'd15, 5'd31, 5'd31);
		send_request(sst_pkg::REQ_INSERT, 4'd1, 5'd0, 5'd1);
		send_request(sst_pkg::REQ_INSERT, 4'd1, 5'd1, 5'd0);
		send_request(sst_pkg::REQ_INSERT, 4'd12, 5'd31, 5'd25);
		send_request(sst_pkg::REQ_INSERT, 4'd12, 5'd31, 5'd31);
		wait_for_results();
	endtask

	// inserts out of order with a duplicate, deletes at both ends, in the middle and of missing keys, lists and a clear
	task automatic test_sorted_order();
		send_request(sst_pkg::REQ_INSERT, 4'd12, 5'd31, 5'd24);
		send_request(sst_pkg::REQ_INSERT, 4'd1, 5'd1, 5'd1);
		send_request(sst_pkg::REQ_INSERT, 4'd6, 5'd15, 5'd12);
		send_request(sst_pkg::REQ_INSERT, 4'd6, 5'd15, 5'd11);
		send_request(sst_pkg::REQ_INSERT, 4'd6, 5'd15, 5'd13);
		send_request(sst_pkg::REQ_INSERT, 4'd12, 5'd31, 5'd24);
		send_request(sst_pkg::REQ_LIST, 4'd3, 5'd7, 5'd9);
		send_request(sst_pkg::REQ_DELETE, 4'd6, 5'd15, 5'd12);
		send_request(sst_pkg::REQ_DELETE, 4'd1, 5'd1, 5'd1);
		send_request(sst_pkg::REQ_DELETE, 4'd12, 5'd31, 5'd24);
		send_request(sst_pkg::REQ_DELETE, 4'd7, 5'd7, 5'd7);
		send_request(sst_pkg::REQ_DELETE, 4'd15, 5'd31, 5'd31);
		send_request(sst_pkg::REQ_LIST, 4'd0, 5'd0, 5'd0);
		send_request(sst_pkg::REQ_CLEAR, 4'd0, 5'd0, 5'd0);
		send_request(sst_pkg::REQ_LIST, 4'd0, 5'd0, 5'd0);
		wait_for_results();
	endtask

	// fill to capacity, then the rejects, a full list, deletes at both ends, two inserts and a list
	task automatic test_full_table();
		logic [13:0] k;
		while (booked.size() < SLOTS) begin
			k = fresh_key();
			send_request(sst_pkg::REQ_INSERT, k[13:10], k[9:5], k[4:0]);
		end
		k = fresh_key();
		send_request(sst_pkg::REQ_INSERT, k[13:10], k[9:5], k[4:0]);
		k = booked[$urandom_range(0, SLOTS - 1)];
		send_request(sst_pkg::REQ_INSERT, k[13:10], k[9:5], k[4:0]);
		send_request(sst_pkg::REQ_INSERT, 4'd14, 5'd0, 5'd26);
		send_request(sst_pkg::REQ_LIST, 4'd0, 5'd0, 5'd0);
		k = booked[0];
		send_request(sst_pkg::REQ_DELETE, k[13:10], k[9:5], k[4:0]);
		k = booked[$];
		send_request(sst_pkg::REQ_DELETE, k[13:10], k[9:5], k[4:0]);
		send_request(sst_pkg::REQ_INSERT, 4'd12, 5'd31, 5'd24);
		send_request(sst_pkg::REQ_INSERT, 4'd1, 5'd1, 5'd1);
		send_request(sst_pkg::REQ_LIST, 4'd0, 5'd0, 5'd0);
		wait_for_results();
	endtask

	// weighted random mix, mostly valid keys and deletes of stored keys
	task automatic test_random_mix(int count);
		int          pick;
		logic [13:0] k;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			k = 14'($urandom);
			if (pick < 45) begin
				if ($urandom_range(0, 9) != 0)
					k = ($urandom_range(0, 4) == 0 && booked.size() != 0) ?
						booked[$urandom_range(0, booked.size() - 1)] : fresh_key();
				send_request(sst_pkg::REQ_INSERT, k[13:10], k[9:5], k[4:0]);
			end else if (pick < 75) begin
				if (booked.size() != 0 && $urandom_range(0, 4) < 3)
					k = booked[$urandom_range(0, booked.size() - 1)];
				send_request(sst_pkg::REQ_DELETE, k[13:10], k[9:5], k[4:0]);
			end else if (pick < 94) begin
				send_request(sst_pkg::REQ_LIST, k[13:10], k[9:5], k[4:0]);
			end else begin
				send_request(sst_pkg::REQ_CLEAR, k[13:10], k[9:5], k[4:0]);
			end
		end
		wait_for_results();
	endtask

	// compare every result with the oldest prediction
	always @(posedge clk) begin
		slot_result_t got;
		slot_result_t want;
		if (arst_n && done) begin
			got.status = sst_pkg::status_t'(status);
			got.key = {out_month, out_day, out_hour};
			got.last = last;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result status=%0d key=%0d/%0d/%0d last=%0b",
					$time, got.status, got.key.month, got.key.day, got.key.hour, got.last);
				mismatches++;
			end else begin
				want = awaited.pop_front();
				results_checked++;
				if (got !== want) begin
					$display("%0t: expected status=%0d key=%0d/%0d/%0d last=%0b", $time,
						want.status, want.key.month, want.key.day, want.key.hour, want.last);
					$display("%0t: actual   status=%0d key=%0d/%0d/%0d last=%0b", $time,
						got.status, got.key.month, got.key.day, got.key.hour, got.last);
					mismatches++;
				end
			end
		end
	end

	// main sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_key_checks();
		test_sorted_order();
		test_full_table();
		test_random_mix(28);
		// last part without idle gaps
		steady = 1'b1;
		test_random_mix(15);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d requests, checked %0d results", requests_sent, results_checked);
		$display("full table hit %0d times, longest list %0d keys", full_seen, longest_list);
		if (mismatches == 0 && awaited.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", awaited.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_mem.sv
rtl/sst_seq.sv
rtl/sorted_slot_table.sv
tb/sv/testbench.sv
